[hw/rtl/sprite_camera_projection_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sprite camera projection unit
// Concurrent checks clocked on clk_i, with or without the reset guard.
// ----------------------------------------------------------------------------
`ifndef SPRITE_CAMERA_PROJECTION_UNIT_ASSERT_SVH
`define SPRITE_CAMERA_PROJECTION_UNIT_ASSERT_SVH

// check while out of reset
`define SCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define SCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Word types and register indexes of the sprite camera projection unit.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VIEWER_POS_X = 3'd0,
    CFG_VIEWER_POS_Y = 3'd1,
    CFG_VIEW_DIR_X   = 3'd2,
    CFG_VIEW_DIR_Y   = 3'd3,
    CFG_CAM_PLANE_X  = 3'd4,
    CFG_CAM_PLANE_Y  = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] ViewDirXRst  = 16'hC000;
  localparam logic [15:0] CamPlaneYRst = 16'd10813;

  typedef struct packed {
    logic [15:0] obj_pos_x;
    logic [15:0] obj_pos_y;
  } scp_in_t;

  typedef struct packed {
    logic signed [15:0] centre_col;
    logic [14:0]        sprite_size;
    logic [8:0]         first_row;
    logic [8:0]         last_row;
    logic [14:0]        first_col;
    logic signed [15:0] last_col;
    logic signed [31:0] view_depth;
    logic               not_visible;
  } scp_out_t;

endpackage

[hw/rtl/sprite_camera_projection_unit.sv]
// Throughput: one word per cycle; the whole pipeline holds while the output
// register is full and stalled.
// Two 32-stage dividers (camera x and depth) and two 16-stage dividers
// (centre column and size) make up most of the pipeline.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// sprite_camera_projection_unit
// Projects a billboard sprite into screen space for a ray-cast view.
// ----------------------------------------------------------------------------
module sprite_camera_projection_unit #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 512
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  scp_pkg::scp_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output scp_pkg::scp_out_t        out_data_o,
  input  logic                     cfg_we_i,
  input  logic [scp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scp_pkg::CfgDataW-1:0] cfg_data_i
);
  import scp_pkg::*;

  localparam int HalfWBits = $clog2(SCREEN_WIDTH / 2 + 1);
  localparam int CNumW     = 33 + HalfWBits + 1;
  localparam int SzNumW    = 47;
  localparam logic signed [CNumW-1:0] HalfWidth = CNumW'(SCREEN_WIDTH / 2);
  localparam logic [SzNumW-1:0] SizeNum = SzNumW'(SCREEN_HEIGHT) << 16;

  // configuration registers
  logic [15:0]        viewer_x_q, viewer_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewer_x_q <= '0;
      viewer_y_q <= '0;
      dir_x_q    <= ViewDirXRst;
      dir_y_q    <= '0;
      plane_x_q  <= '0;
      plane_y_q  <= CamPlaneYRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIEWER_POS_X: viewer_x_q <= cfg_data_i;
        CFG_VIEWER_POS_Y: viewer_y_q <= cfg_data_i;
        CFG_VIEW_DIR_X:   dir_x_q    <= cfg_data_i;
        CFG_VIEW_DIR_Y:   dir_y_q    <= cfg_data_i;
        CFG_CAM_PLANE_X:  plane_x_q  <= cfg_data_i;
        CFG_CAM_PLANE_Y:  plane_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: hold everything while the output word is stalled
  logic out_valid_q;
  logic en;
  assign en         = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~en;

  // stage 1: relative position and products
  logic signed [16:0] rx, ry;
  assign rx = $signed({1'b0, in_data_i.obj_pos_x}) - $signed({1'b0, viewer_x_q});
  assign ry = $signed({1'b0, in_data_i.obj_pos_y}) - $signed({1'b0, viewer_y_q});

  logic               v1_q;
  logic signed [32:0] p_dyrx_q, p_dxry_q, p_plxry_q, p_plyrx_q;
  logic signed [31:0] det_a_q, det_b_q;

  // stage 2
  logic               v2_q;
  logic signed [33:0] nx_q, ny_q;
  logic signed [32:0] det_q;

  // stage 3
  logic        v3_q;
  logic [32:0] nx_mag_q, ny_mag_q;
  logic [31:0] det_mag_q;
  logic        sx3_q, sy3_q, dz3_q;

  // stage 4
  logic        v4_q;
  logic [63:0] num_x_q, num_y_q;
  logic [31:0] den4_q;
  logic        sx4_q, sy4_q, ovx4_q, ovy4_q, dz4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_dyrx_q  <= 33'(dir_y_q) * 33'(rx);
      p_dxry_q  <= 33'(dir_x_q) * 33'(ry);
      p_plxry_q <= 33'(plane_x_q) * 33'(ry);
      p_plyrx_q <= 33'(plane_y_q) * 33'(rx);
      det_a_q   <= 32'(plane_x_q) * 32'(dir_y_q);
      det_b_q   <= 32'(dir_x_q) * 32'(plane_y_q);

      nx_q  <= 34'(p_dyrx_q) - 34'(p_dxry_q);
      ny_q  <= 34'(p_plxry_q) - 34'(p_plyrx_q);
      det_q <= 33'(det_a_q) - 33'(det_b_q);

      nx_mag_q  <= nx_q[33] ? 33'(-nx_q) : nx_q[32:0];
      ny_mag_q  <= ny_q[33] ? 33'(-ny_q) : ny_q[32:0];
      det_mag_q <= det_q[32] ? 32'(-det_q) : det_q[31:0];
      sx3_q     <= nx_q[33] ^ det_q[32];
      sy3_q     <= ny_q[33] ^ det_q[32];
      dz3_q     <= (det_q == '0);

      ovx4_q  <= {9'd0, nx_mag_q} >= {det_mag_q, 10'd0};
      ovy4_q  <= {9'd0, ny_mag_q} >= {det_mag_q, 10'd0};
      num_x_q <= ({9'd0, nx_mag_q} >= {det_mag_q, 10'd0}) ? '0 : {9'd0, nx_mag_q, 22'd0};
      num_y_q <= ({9'd0, ny_mag_q} >= {det_mag_q, 10'd0}) ? '0 : {9'd0, ny_mag_q, 22'd0};
      den4_q  <= det_mag_q;
      sx4_q   <= sx3_q;
      sy4_q   <= sy3_q;
      dz4_q   <= dz3_q;
    end
  end

  // camera x and depth dividers
  logic        vx_div, vy_div;
  logic [31:0] qx, qy;
  logic [1:0]  side_x;
  logic [2:0]  side_y;

  scp_div #(.DEN_W(32), .QUOT_W(32), .SIDE_W(2)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num_x_q),
    .den_i   (den4_q),
    .side_i  ({sx4_q, ovx4_q}),
    .valid_o (vx_div),
    .quot_o  (qx),
    .side_o  (side_x)
  );

  scp_div #(.DEN_W(32), .QUOT_W(32), .SIDE_W(3)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num_y_q),
    .den_i   (den4_q),
    .side_i  ({sy4_q, ovy4_q, dz4_q}),
    .valid_o (vy_div),
    .quot_o  (qy),
    .side_o  (side_y)
  );

  function automatic logic signed [31:0] sat32(logic [31:0] q, logic neg, logic ovf);
    logic signed [31:0] r;
    if (ovf) begin
      r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (!neg) begin
      r = q[31] ? 32'sh7FFF_FFFF : $signed(q);
    end else begin
      r = (q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-q);
    end
    return r;
  endfunction

  // stage 5: saturated camera x and depth
  logic               v5_q, dz5_q;
  logic signed [31:0] tx5_q, ty5_q;
  // stage 6
  logic               v6_q, dz6_q, vis6_q;
  logic signed [32:0] sum6_q;
  logic signed [31:0] ty6_q;
  // stage 7
  logic               v7_q, dz7_q, vis7_q, szov7_q;
  logic signed [CNumW-1:0] cnum7_q;
  logic signed [31:0] ty7_q;
  // stage 8
  logic               v8_q, dz8_q, vis8_q, szov8_q, cneg8_q;
  logic [CNumW-2:0]   cmag8_q;
  logic signed [31:0] ty8_q;
  // stage 9
  logic               v9_q, dz9_q, vis9_q, szov9_q, cneg9_q, cov9_q;
  logic [SzNumW-1:0]  cnum9_q, snum9_q;
  logic signed [31:0] ty9_q;

  logic cov8;
  assign cov8 = SzNumW'(cmag8_q) >= {ty8_q[30:0], 16'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v5_q <= vx_div & vy_div;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx5_q <= sat32(qx, side_x[1], side_x[0]);
      ty5_q <= sat32(qy, side_y[2], side_y[1]);
      dz5_q <= side_y[0];

      sum6_q <= 33'(tx5_q) + 33'(ty5_q);
      ty6_q  <= ty5_q;
      dz6_q  <= dz5_q;
      vis6_q <= ~dz5_q & ~ty5_q[31] & (ty5_q != '0);

      cnum7_q <= CNumW'(sum6_q) * HalfWidth;
      szov7_q <= ty6_q <= $signed(32'(SCREEN_HEIGHT));
      ty7_q   <= ty6_q;
      dz7_q   <= dz6_q;
      vis7_q  <= vis6_q;

      cmag8_q <= cnum7_q[CNumW-1] ? (CNumW-1)'(-cnum7_q) : cnum7_q[CNumW-2:0];
      cneg8_q <= cnum7_q[CNumW-1];
      szov8_q <= szov7_q;
      ty8_q   <= ty7_q;
      dz8_q   <= dz7_q;
      vis8_q  <= vis7_q;

      cov9_q  <= cov8;
      cnum9_q <= (cov8 || !vis8_q) ? '0 : SzNumW'(cmag8_q);
      snum9_q <= (szov8_q || !vis8_q) ? '0 : SizeNum;
      cneg9_q <= cneg8_q;
      szov9_q <= szov8_q;
      ty9_q   <= ty8_q;
      dz9_q   <= dz8_q;
      vis9_q  <= vis8_q;
    end
  end

  // centre column and size dividers
  logic        vc_div, vs_div;
  logic [15:0] qc, qs;
  logic [35:0] side_c;
  logic        side_s;

  scp_div #(.DEN_W(31), .QUOT_W(16), .SIDE_W(36)) u_div_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v9_q),
    .num_i   (cnum9_q),
    .den_i   (ty9_q[30:0]),
    .side_i  ({vis9_q, cneg9_q, cov9_q, dz9_q, ty9_q}),
    .valid_o (vc_div),
    .quot_o  (qc),
    .side_o  (side_c)
  );

  scp_div #(.DEN_W(31), .QUOT_W(16), .SIDE_W(1)) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v9_q),
    .num_i   (snum9_q),
    .den_i   (ty9_q[30:0]),
    .side_i  (szov9_q),
    .valid_o (vs_div),
    .quot_o  (qs),
    .side_o  (side_s)
  );

  // stage 10: saturate centre and size
  logic               v10_q, vis10_q, dz10_q;
  logic signed [15:0] centre10_q;
  logic [14:0]        size10_q;
  logic signed [31:0] ty10_q;
  logic signed [15:0] centre_d;
  logic [14:0]        size_d;

  always_comb begin
    if (side_c[33]) begin
      centre_d = side_c[34] ? 16'sh8000 : 16'sh7FFF;
    end else if (!side_c[34]) begin
      centre_d = qc[15] ? 16'sh7FFF : $signed(qc);
    end else begin
      centre_d = (qc > 16'h8000) ? 16'sh8000 : $signed(-qc);
    end
    if (side_s || qs[15]) begin
      size_d = 15'h7FFF;
    end else begin
      size_d = qs[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else if (en) begin
      v10_q <= vc_div & vs_div;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      centre10_q <= centre_d;
      size10_q   <= size_d;
      vis10_q    <= side_c[35];
      dz10_q     <= side_c[32];
      ty10_q     <= $signed(side_c[31:0]);
    end
  end

  // stage 11: clip rows and columns into the output register
  logic [13:0]        half;
  logic signed [17:0] r0, r1, c0, c1;
  scp_out_t           out_d, out_q;

  assign half = size10_q[14:1];

  always_comb begin
    r0 = $signed(18'(SCREEN_HEIGHT / 2)) - $signed({4'd0, half});
    r1 = $signed(18'(SCREEN_HEIGHT / 2)) + $signed({4'd0, half});
    c0 = 18'(centre10_q) - $signed({4'd0, half});
    c1 = 18'(centre10_q) + $signed({4'd0, half});
    if (r0 < 0) begin
      r0 = '0;
    end
    if (r1 >= $signed(18'(SCREEN_HEIGHT))) begin
      r1 = 18'(SCREEN_HEIGHT - 1);
    end
    if (c0 < 0) begin
      c0 = '0;
    end
    if (c1 >= $signed(18'(SCREEN_WIDTH))) begin
      c1 = 18'(SCREEN_WIDTH - 1);
    end
    out_d = '0;
    out_d.not_visible = ~vis10_q;
    out_d.view_depth  = dz10_q ? '0 : ty10_q;
    if (vis10_q) begin
      out_d.centre_col  = centre10_q;
      out_d.sprite_size = size10_q;
      out_d.first_row   = r0[8:0];
      out_d.last_row    = r1[8:0];
      out_d.first_col   = c0[14:0];
      out_d.last_col    = c1[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "sprite_camera_projection_unit_assert.svh"

  `SCP_ASSERT(a_vis_depth_pos, out_valid_o && !out_data_o.not_visible |-> !out_data_o.view_depth[31] && out_data_o.view_depth != 0, "visible word with non-positive depth")
  `SCP_ASSERT(a_hidden_zero, out_valid_o && out_data_o.not_visible |-> out_data_o.centre_col == 0 && out_data_o.sprite_size == 0, "hidden word carries geometry")
  `SCP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

[hw/rtl/scp_div.sv]
// ----------------------------------------------------------------------------
// scp_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// The dividend must be below den_i shifted left by QUOT_W.
// ----------------------------------------------------------------------------
module scp_div #(
  parameter int DEN_W  = 32,
  parameter int QUOT_W = 32,
  parameter int SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [DEN_W+QUOT_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic [QUOT_W-1:0]       quot_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int RemW = DEN_W + QUOT_W;

  logic              valid_q [QUOT_W];
  logic [RemW-1:0]   rem_q   [QUOT_W];
  logic [DEN_W-1:0]  den_q   [QUOT_W];
  logic [QUOT_W-1:0] quot_q  [QUOT_W];
  logic [SIDE_W-1:0] side_q  [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    localparam int QBit = QUOT_W - 1 - k;

    logic              vld_src;
    logic [RemW-1:0]   rem_src;
    logic [DEN_W-1:0]  den_src;
    logic [QUOT_W-1:0] quot_src;
    logic [SIDE_W-1:0] side_src;
    logic [RemW-1:0]   den_sh;
    logic [RemW:0]     trial;
    logic [RemW-1:0]   rem_d;
    logic [QUOT_W-1:0] quot_d;

    if (k == 0) begin : g_first
      assign vld_src  = valid_i;
      assign rem_src  = num_i;
      assign den_src  = den_i;
      assign quot_src = '0;
      assign side_src = side_i;
    end else begin : g_next
      assign vld_src  = valid_q[k-1];
      assign rem_src  = rem_q[k-1];
      assign den_src  = den_q[k-1];
      assign quot_src = quot_q[k-1];
      assign side_src = side_q[k-1];
    end

    assign den_sh = RemW'(den_src) << QBit;
    assign trial  = {1'b0, rem_src} - {1'b0, den_sh};

    always_comb begin
      quot_d       = quot_src;
      quot_d[QBit] = ~trial[RemW];
      rem_d        = trial[RemW] ? rem_src : trial[RemW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_src;
        quot_q[k] <= quot_d;
        side_q[k] <= side_src;
      end
    end
  end

  assign valid_o = valid_q[QUOT_W-1];
  assign quot_o  = quot_q[QUOT_W-1];
  assign side_o  = side_q[QUOT_W-1];

endmodule
